FILE: hdl/dfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dfpa_pkg
// Shared types and constants of the decimal fixed-point ALU pipeline.
// ---------------------------------------------------------------------------
package dfpa_pkg;

  localparam int unsigned SCALE  = 1000;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SUM_W  = WORD_W + 1;
  localparam int unsigned PROD_W = 2 * WORD_W;
  // |a| * 1000 < 2^41; a product at or above 2^41 saturates whatever its low bits
  localparam int unsigned NUM_W  = 41;
  localparam int unsigned DEN_W  = WORD_W;
  localparam int unsigned REM_W  = DEN_W + 1;

  localparam logic [DEN_W-1:0]  SCALE_DEN = DEN_W'(SCALE);
  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2
  } status_t;

  // Word carried through the long-division stages
  typedef struct packed {
    op_t                     op;
    logic                    neg;
    logic signed [SUM_W-1:0] sum;
    logic [DEN_W-1:0]        den;
    logic [REM_W-1:0]        rem;
    logic [NUM_W-1:0]        num;
  } div_word_t;

endpackage
`default_nettype wire

FILE: hdl/dfpa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dfpa_req_if
// Request channel: operation code and two scaled operands.
// ---------------------------------------------------------------------------
interface dfpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

FILE: hdl/dfpa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dfpa_rsp_if
// Response channel: scaled result and status code.
// ---------------------------------------------------------------------------
interface dfpa_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [1:0]  status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/dfpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dfpa_front
// Two stages: sign/magnitude split with add/subtract, then the 32x32
// multiply that forms either the product or the scaled dividend.
// ---------------------------------------------------------------------------
module dfpa_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire dfpa_pkg::op_t               in_op,
  input  wire logic [dfpa_pkg::WORD_W-1:0] a,
  input  wire logic [dfpa_pkg::WORD_W-1:0] b,
  output logic                             out_valid,
  output dfpa_pkg::div_word_t              out_word
);

  logic [dfpa_pkg::WORD_W-1:0] mag_a_c, mag_b_c;
  logic [dfpa_pkg::SUM_W-1:0]  ext_a, ext_b;

  logic                              v1;
  dfpa_pkg::op_t                     op1;
  logic                              neg1;
  logic signed [dfpa_pkg::SUM_W-1:0] sum1;
  logic [dfpa_pkg::WORD_W-1:0]       mag_a1, rhs1;
  logic [dfpa_pkg::DEN_W-1:0]        den1;

  logic                              v2;
  dfpa_pkg::op_t                     op2;
  logic                              neg2;
  logic signed [dfpa_pkg::SUM_W-1:0] sum2;
  logic [dfpa_pkg::DEN_W-1:0]        den2;
  logic [dfpa_pkg::PROD_W-1:0]       prod2;

  always_comb begin
    mag_a_c = a[dfpa_pkg::WORD_W-1] ? (~a + 1'b1) : a;
    mag_b_c = b[dfpa_pkg::WORD_W-1] ? (~b + 1'b1) : b;
    ext_a   = {a[dfpa_pkg::WORD_W-1], a};
    ext_b   = {b[dfpa_pkg::WORD_W-1], b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= in_op;
      neg1   <= a[dfpa_pkg::WORD_W-1] ^ b[dfpa_pkg::WORD_W-1];
      sum1   <= (in_op == dfpa_pkg::OP_SUB) ? $signed(ext_a - ext_b) : $signed(ext_a + ext_b);
      mag_a1 <= mag_a_c;
      // multiply uses |b| as the right factor, divide scales the dividend by 1000
      rhs1   <= (in_op == dfpa_pkg::OP_MUL) ? mag_b_c : dfpa_pkg::SCALE_DEN;
      den1   <= (in_op == dfpa_pkg::OP_MUL) ? dfpa_pkg::SCALE_DEN : mag_b_c;

      op2    <= op1;
      neg2   <= neg1;
      sum2   <= sum1;
      den2   <= den1;
      prod2  <= dfpa_pkg::PROD_W'(mag_a1) * dfpa_pkg::PROD_W'(rhs1);
    end
  end

  always_comb begin
    out_valid     = v2;
    out_word.op   = op2;
    out_word.neg  = neg2;
    out_word.sum  = sum2;
    out_word.den  = den2;
    out_word.rem  = '0;
    // clamp: anything this large overflows after the division anyway
    out_word.num  = (|prod2[dfpa_pkg::PROD_W-1:dfpa_pkg::NUM_W]) ? '1
                                                                : prod2[dfpa_pkg::NUM_W-1:0];
  end

endmodule
`default_nettype wire

FILE: hdl/dfpa_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dfpa_div_step
// One restoring long-division step: one quotient bit per stage.
// ---------------------------------------------------------------------------
module dfpa_div_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire dfpa_pkg::div_word_t in_word,
  output logic                     out_valid,
  output dfpa_pkg::div_word_t      out_word
);

  logic [dfpa_pkg::REM_W-1:0] trial;
  logic [dfpa_pkg::REM_W-1:0] den_ext;
  logic                       ge;
  dfpa_pkg::div_word_t        word_next;

  always_comb begin
    // shift the next dividend bit into the partial remainder
    trial   = {in_word.rem[dfpa_pkg::REM_W-2:0], in_word.num[dfpa_pkg::NUM_W-1]};
    den_ext = dfpa_pkg::REM_W'(in_word.den);
    ge      = (trial >= den_ext);
    word_next     = in_word;
    word_next.rem = ge ? (trial - den_ext) : trial;
    word_next.num = {in_word.num[dfpa_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dfpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dfpa_back
// Output stage: restore sign, saturate to 32 bits and form the status.
// ---------------------------------------------------------------------------
module dfpa_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire dfpa_pkg::div_word_t     in_word,
  output logic                         out_valid,
  output logic [dfpa_pkg::WORD_W-1:0]  result,
  output dfpa_pkg::status_t            status
);

  logic [dfpa_pkg::WORD_W-1:0] result_next;
  dfpa_pkg::status_t           status_next;
  logic [dfpa_pkg::NUM_W-1:0]  q;
  logic [dfpa_pkg::WORD_W-1:0] q_low;

  always_comb begin
    q           = in_word.num;
    q_low       = q[dfpa_pkg::WORD_W-1:0];
    result_next = '0;
    status_next = dfpa_pkg::ST_OK;
    case (in_word.op)
      dfpa_pkg::OP_ADD, dfpa_pkg::OP_SUB: begin
        if (!in_word.sum[dfpa_pkg::SUM_W-1] && in_word.sum[dfpa_pkg::WORD_W-1]) begin
          result_next = dfpa_pkg::WORD_MAX;
          status_next = dfpa_pkg::ST_OVERFLOW;
        end else if (in_word.sum[dfpa_pkg::SUM_W-1] && !in_word.sum[dfpa_pkg::WORD_W-1]) begin
          result_next = dfpa_pkg::WORD_MIN;
          status_next = dfpa_pkg::ST_OVERFLOW;
        end else begin
          result_next = in_word.sum[dfpa_pkg::WORD_W-1:0];
        end
      end
      dfpa_pkg::OP_MUL, dfpa_pkg::OP_DIV: begin
        if (in_word.op == dfpa_pkg::OP_DIV && in_word.den == '0) begin
          status_next = dfpa_pkg::ST_DIVZERO;
        end else if (!in_word.neg && q > dfpa_pkg::NUM_W'(dfpa_pkg::WORD_MAX)) begin
          result_next = dfpa_pkg::WORD_MAX;
          status_next = dfpa_pkg::ST_OVERFLOW;
        end else if (in_word.neg && q > dfpa_pkg::NUM_W'(dfpa_pkg::WORD_MIN)) begin
          result_next = dfpa_pkg::WORD_MIN;
          status_next = dfpa_pkg::ST_OVERFLOW;
        end else begin
          result_next = in_word.neg ? (~q_low + 1'b1) : q_low;
        end
      end
      default: begin
        result_next = '0;
        status_next = dfpa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
      status <= status_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/decimal_fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// decimal_fixed_point_alu
// Add, subtract, multiply and divide on signed 32-bit values scaled by 1000.
// ---------------------------------------------------------------------------
// Takes one request per cycle while no response waits unread, and returns one
// response per request, in order: two front stages (operand split, then a 32x32
// multiply), 41 restoring division stages that produce one quotient bit
// each, and one saturation stage that is also the output register. Every
// operation runs through the same 44 stages; multiply divides the product by
// 1000 and divide divides the scaled dividend by the divisor in that shared
// division chain. The whole pipeline holds while a response waits unread, so
// a new request is taken whenever the output register is empty or being read.
module decimal_fixed_point_alu (
  input  wire logic clk,
  input  wire logic rst,
  dfpa_req_if.sink   req,
  dfpa_rsp_if.source rsp
);

  logic                en;
  logic                front_valid;
  dfpa_pkg::div_word_t front_word;

  logic                chain_valid [dfpa_pkg::NUM_W+1];
  dfpa_pkg::div_word_t chain_word  [dfpa_pkg::NUM_W+1];

  logic [dfpa_pkg::WORD_W-1:0] result;
  dfpa_pkg::status_t           status;
  logic                        out_valid;

  // advance everything unless a response is stuck at the output
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  dfpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_op     (dfpa_pkg::op_t'(req.req_type)),
    .a         (req.operand_a),
    .b         (req.operand_b),
    .out_valid (front_valid),
    .out_word  (front_word)
  );

  assign chain_valid[0] = front_valid;
  assign chain_word[0]  = front_word;

  for (genvar i = 0; i < dfpa_pkg::NUM_W; i++) begin : g_div
    dfpa_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  dfpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[dfpa_pkg::NUM_W]),
    .in_word   (chain_word[dfpa_pkg::NUM_W]),
    .out_valid (out_valid),
    .result    (result),
    .status    (status)
  );

  assign rsp.valid        = out_valid;
  assign rsp.result_value = result;
  assign rsp.status       = status;

`ifndef SYNTHESIS
  a_divzero_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == dfpa_pkg::ST_DIVZERO) |-> (result == '0))
    else $error("divide-by-zero response with nonzero result");

  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == dfpa_pkg::ST_OVERFLOW) |->
      (result == dfpa_pkg::WORD_MAX || result == dfpa_pkg::WORD_MIN))
    else $error("overflow response not saturated to a bound");

  a_no_code3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == dfpa_pkg::ST_OK || status == dfpa_pkg::ST_OVERFLOW ||
                   status == dfpa_pkg::ST_DIVZERO))
    else $error("undefined status code");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(result) && $stable(status)
                                   && !$past(en)))
    else $error("pipeline advanced under output stall");
`endif

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks decimal_fixed_point_alu: a directed table of edge operands, then
// mixed random requests. Each accepted request takes its expected response from
// its typed-in row or a local model of the scaled arithmetic. Responses are
// compared in order while the sender bursts and the receiver stalls at random.
// ---------------------------------------------------------------------------
module tb;

  localparam int     NUM_DIRECTED = 24;
  localparam int     NUM_RANDOM   = 1050;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam longint SAT_HI       = 64'sd2147483647;
  localparam longint SAT_LO       = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    dfpa_pkg::status_t  status;
  } alu_rsp_t;

  typedef struct packed {
    dfpa_pkg::op_t      op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               typed;
    alu_rsp_t           rsp;
  } alu_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dfpa_req_if req_if ();
  dfpa_rsp_if rsp_if ();

  decimal_fixed_point_alu i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #10 clk = ~clk;

  alu_rsp_t pending_q[$];
  int       mismatches = 0;
  int       cycle = 0;
  int       burst_left = 0;
  int       stall_left = 0;

  // Typed-in rows carry their result; the others go through the model
  alu_row_t directed_rows [NUM_DIRECTED] = '{
    '{dfpa_pkg::OP_ADD, 32'sd0, 32'sd0, 1'b1,
      '{32'sd0, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_ADD, dfpa_pkg::WORD_MAX, 32'sd1, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_ADD, dfpa_pkg::WORD_MIN, -32'sd1, 1'b1,
      '{dfpa_pkg::WORD_MIN, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_ADD, dfpa_pkg::WORD_MAX, dfpa_pkg::WORD_MAX, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_ADD, 32'sd12345, -32'sd678, 1'b0,
      '{32'sd0, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_SUB, dfpa_pkg::WORD_MIN, 32'sd1, 1'b1,
      '{dfpa_pkg::WORD_MIN, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_SUB, 32'sd0, dfpa_pkg::WORD_MIN, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_SUB, dfpa_pkg::WORD_MAX, dfpa_pkg::WORD_MAX, 1'b1,
      '{32'sd0, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_SUB, -32'sd5000, 32'sd7250, 1'b0,
      '{32'sd0, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_MUL, 32'sd1000, 32'sd1000, 1'b1,
      '{32'sd1000, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_MUL, dfpa_pkg::WORD_MAX, dfpa_pkg::WORD_MAX, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_MUL, dfpa_pkg::WORD_MIN, dfpa_pkg::WORD_MAX, 1'b1,
      '{dfpa_pkg::WORD_MIN, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_MUL, dfpa_pkg::WORD_MIN, dfpa_pkg::WORD_MIN, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_MUL, -32'sd1, 32'sd999, 1'b1,
      '{32'sd0, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_MUL, -32'sd2500, 32'sd4123, 1'b0,
      '{32'sd0, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_DIV, dfpa_pkg::WORD_MAX, 32'sd0, 1'b1,
      '{32'sd0, dfpa_pkg::ST_DIVZERO}},
    '{dfpa_pkg::OP_DIV, dfpa_pkg::WORD_MIN, 32'sd0, 1'b1,
      '{32'sd0, dfpa_pkg::ST_DIVZERO}},
    '{dfpa_pkg::OP_DIV, 32'sd0, 32'sd0, 1'b1,
      '{32'sd0, dfpa_pkg::ST_DIVZERO}},
    '{dfpa_pkg::OP_DIV, 32'sd1000, 32'sd1000, 1'b1,
      '{32'sd1000, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_DIV, dfpa_pkg::WORD_MIN, -32'sd1, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_DIV, dfpa_pkg::WORD_MAX, 32'sd1, 1'b1,
      '{dfpa_pkg::WORD_MAX, dfpa_pkg::ST_OVERFLOW}},
    '{dfpa_pkg::OP_DIV, -32'sd1, 32'sd3, 1'b1,
      '{-32'sd333, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_DIV, dfpa_pkg::WORD_MIN, dfpa_pkg::WORD_MIN, 1'b1,
      '{32'sd1000, dfpa_pkg::ST_OK}},
    '{dfpa_pkg::OP_DIV, 32'sd7, -32'sd2000, 1'b0,
      '{32'sd0, dfpa_pkg::ST_OK}}
  };

  function automatic alu_rsp_t scaled_result(dfpa_pkg::op_t op, logic signed [31:0] a,
                                             logic signed [31:0] b);
    longint   la;
    longint   lb;
    longint   wide;
    alu_rsp_t r;
    la = a;
    lb = b;
    r.status = dfpa_pkg::ST_OK;
    case (op)
      dfpa_pkg::OP_ADD: wide = la + lb;
      dfpa_pkg::OP_SUB: wide = la - lb;
      dfpa_pkg::OP_MUL: wide = (la * lb) / longint'(dfpa_pkg::SCALE);
      default: begin
        if (lb == 0) begin
          r.value  = '0;
          r.status = dfpa_pkg::ST_DIVZERO;
          return r;
        end
        wide = (la * longint'(dfpa_pkg::SCALE)) / lb;
      end
    endcase
    if (wide > SAT_HI) begin
      wide     = SAT_HI;
      r.status = dfpa_pkg::ST_OVERFLOW;
    end else if (wide < SAT_LO) begin
      wide     = SAT_LO;
      r.status = dfpa_pkg::ST_OVERFLOW;
    end
    r.value = wide[31:0];
    return r;
  endfunction

  // Bias operands toward the saturation and truncation boundaries
  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4:    v = $signed($urandom_range(200000)) - 32'sd100000;
      5:       v = dfpa_pkg::WORD_MAX - $urandom_range(3);
      6:       v = dfpa_pkg::WORD_MIN + $urandom_range(3);
      7:       v = $signed($urandom_range(2)) - 32'sd1;
      8:       v = ($signed($urandom_range(4000)) - 32'sd2000) * 32'sd1000;
      default: begin
        // near sqrt(2^31 * 1000), where a product starts to saturate
        v = 32'sd1464000 + $urandom_range(3000);
        if ($urandom_range(1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_word(input alu_row_t row);
    alu_rsp_t r;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= row.op;
    req_if.operand_a <= row.a;
    req_if.operand_b <= row.b;
    do @(posedge clk); while (!req_if.ready);
    r = row.typed ? row.rsp : scaled_result(row.op, row.a, row.b);
    pending_q.push_back(r);
  endtask

  task automatic issue_word(input alu_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
      // lower valid only when a real gap follows
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_word(row);
  endtask

  initial begin
    alu_row_t row;
    req_if.valid     = 1'b0;
    req_if.req_type  = dfpa_pkg::OP_ADD;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) issue_word(directed_rows[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      row.op    = dfpa_pkg::op_t'($urandom_range(3));
      row.a     = pick_operand();
      row.b     = ($urandom_range(15) == 0) ? 32'sd0 : pick_operand();
      row.typed = 1'b0;
      row.rsp   = '0;
      issue_word(row);
    end
    req_if.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: the stall style follows bits 8:7 of the cycle count
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (cycle[8:7])
        2'd0: rsp_if.ready <= 1'b1;
        2'd1: rsp_if.ready <= ($urandom_range(3) != 0);
        2'd2: rsp_if.ready <= (cycle % 5 != 0);
        default: begin
          if ($urandom_range(15) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(5, 30);
          end else begin
            rsp_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    alu_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word, actual value %0d status %0d", $realtime,
                 rsp_if.result_value, rsp_if.status);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (rsp_if.result_value !== want.value) begin
          $display("%0t: result_value expected %0d actual %0d", $realtime,
                   want.value, rsp_if.result_value);
          mismatches++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, rsp_if.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $realtime, pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
